>>> src/sha1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha1_pkg;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [6:0] ROUNDS = 7'd80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       clear;      // restore IV and count
    logic       absorb;     // write byte at current position
    logic [7:0] byte_val;
    logic       count_en;   // advance bit count
    logic       round_init; // load a..e from chaining words
    logic       round_step;
    logic       round_fold; // add a..e into chaining words
    logic       save_len;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       blk_full;   // position is 63
    logic [5:0] pos;
    logic [6:0] round;
    logic [63:0] len;
  } dp_sts_t;
endpackage
`default_nettype wire

>>> src/sha1_message_digest.sv
`timescale 1ns / 1ps
`default_nettype none
// SHA-1 digest of a byte stream. A byte that fills a 64-byte block starts the
// compression loop, one round per cycle. End of message: padding bytes up to
// offset 56, 8 length bytes, a compression per filled block, then 5 digest
// words through a one-entry output register.
// rst_n (synchronous, active low) restores the initial hash value and zero count.
module sha1_message_digest (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // [7:0] data_byte, [8] has_byte, zero fill
  input  wire logic        in_tlast,  // end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic             out_tlast   // last_word
);
  sha1_pkg::dp_cmd_t cmd;
  sha1_pkg::dp_sts_t sts;
  logic        in_fire, oreg_load, oreg_free;
  logic [2:0]  out_sel;
  logic [31:0] dword;
  logic [31:0] word_r;
  logic [2:0]  widx_r;
  logic        vld_r;

  assign in_fire = in_tvalid && in_tready;
  assign oreg_free = !vld_r || out_tready;

  sha1_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .in_byte(in_tdata[7:0]), .in_has(in_tdata[8]), .in_end(in_tlast),
    .in_ready(in_tready), .sts(sts), .cmd(cmd),
    .oreg_load(oreg_load), .out_sel(out_sel), .oreg_free(oreg_free)
  );

  sha1_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .out_sel(out_sel),
    .digest_word(dword), .sts(sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (oreg_load) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (oreg_load) begin
      word_r <= dword;
      widx_r <= out_sel;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata = {5'd0, widx_r, word_r};
  assign out_tlast = (widx_r == 3'd4);
endmodule
`default_nettype wire

>>> src/sha1_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module sha1_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sha1_pkg::dp_cmd_t cmd,
  input  wire logic [2:0]       out_sel,
  output logic [31:0]           digest_word,
  output sha1_pkg::dp_sts_t     sts
);
  logic [31:0] h_r [5];
  logic [31:0] w_r [16];
  logic [63:0] cnt_r;
  logic [63:0] len_r;
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [6:0]  rnd_r;

  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [4:0]  sh;
  logic [31:0] wt, wx, f, k, tmp, nw;

  assign pos = cnt_r[8:3];
  assign wi  = pos[5:2];
  assign sh  = {~pos[1:0], 3'b000};
  assign sts.pos = pos;
  assign sts.blk_full = (pos == 6'd63);
  assign sts.round = rnd_r;
  assign sts.len = len_r;

  always_comb begin
    nw = {24'd0, cmd.byte_val} << sh;
    wx = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
    wt = (rnd_r < 7'd16) ? w_r[0] : {wx[30:0], wx[31]};
    if (rnd_r < 7'd20) begin
      f = (b_r & c_r) | (~b_r & d_r);
      k = sha1_pkg::K0;
    end else if (rnd_r < 7'd40) begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K1;
    end else if (rnd_r < 7'd60) begin
      f = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k = sha1_pkg::K2;
    end else begin
      f = b_r ^ c_r ^ d_r;
      k = sha1_pkg::K3;
    end
    tmp = {a_r[26:0], a_r[31:27]} + f + e_r + k + wt;
  end

  assign digest_word = h_r[out_sel];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      h_r[0] <= sha1_pkg::H0;
      h_r[1] <= sha1_pkg::H1;
      h_r[2] <= sha1_pkg::H2;
      h_r[3] <= sha1_pkg::H3;
      h_r[4] <= sha1_pkg::H4;
      cnt_r  <= 64'd0;
      rnd_r  <= 7'd0;
    end else begin
      if (cmd.count_en) cnt_r <= cnt_r + 64'd8;
      if (cmd.round_init) begin
        rnd_r <= 7'd0;
      end else if (cmd.round_step) begin
        rnd_r <= rnd_r + 7'd1;
      end
      // fold comes with the last round step; add the values that step produces
      if (cmd.round_fold) begin
        h_r[0] <= h_r[0] + tmp;
        h_r[1] <= h_r[1] + a_r;
        h_r[2] <= h_r[2] + {b_r[1:0], b_r[31:2]};
        h_r[3] <= h_r[3] + c_r;
        h_r[4] <= h_r[4] + d_r;
      end
    end
  end

  // message schedule as a 16-deep shift line; slot 0 holds W[t] for t < 16, W[t-16] after
  always_ff @(posedge clk) begin
    if (cmd.save_len) len_r <= cnt_r;
    if (cmd.absorb) begin
      if (pos[1:0] == 2'd0) w_r[wi] <= nw;
      else w_r[wi] <= w_r[wi] | nw;
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wt;
    end
    if (cmd.round_init) begin
      a_r <= h_r[0];
      b_r <= h_r[1];
      c_r <= h_r[2];
      d_r <= h_r[3];
      e_r <= h_r[4];
    end else if (cmd.round_step) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end
endmodule
`default_nettype wire

>>> src/sha1_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sha1_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_has,
  input  wire logic              in_end,
  output logic                   in_ready,
  input  wire sha1_pkg::dp_sts_t sts,
  output sha1_pkg::dp_cmd_t      cmd,
  output logic                   oreg_load,
  output logic [2:0]             out_sel,
  input  wire logic              oreg_free
);
  sha1_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] lb_r, lb_nxt;   // length byte index
  logic       pad1_r, pad1_nxt; // 0x80 still to append

  assign out_sel = idx_r;

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    idx_nxt = idx_r;
    lb_nxt = lb_r;
    pad1_nxt = pad1_r;
    unique case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_has && sts.blk_full) begin
            state_nxt = sha1_pkg::ST_ROUND;
            ret_nxt = in_end ? sha1_pkg::ST_PAD : sha1_pkg::ST_IDLE;
          end else if (in_end) begin
            state_nxt = sha1_pkg::ST_PAD;
          end
          pad1_nxt = 1'b1;
          lb_nxt = 3'd0;
        end
      end
      sha1_pkg::ST_ROUND: begin
        if (sts.round == sha1_pkg::ROUNDS - 7'd1) state_nxt = ret_r;
      end
      sha1_pkg::ST_PAD: begin
        pad1_nxt = 1'b0;
        if (sts.blk_full) begin
          state_nxt = sha1_pkg::ST_ROUND;
          ret_nxt = sha1_pkg::ST_PAD;
        end else if (sts.pos + 6'd1 == sha1_pkg::LEN_POS) begin
          state_nxt = sha1_pkg::ST_LEN;
        end
      end
      sha1_pkg::ST_LEN: begin
        lb_nxt = lb_r + 3'd1;
        if (lb_r == 3'd7) begin
          state_nxt = sha1_pkg::ST_ROUND;
          ret_nxt = sha1_pkg::ST_OUT;
          idx_nxt = 3'd0;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (oreg_free) begin
          idx_nxt = (idx_r == 3'd4) ? 3'd0 : idx_r + 3'd1;
          if (idx_r == 3'd4) state_nxt = sha1_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sha1_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    oreg_load = 1'b0;
    unique case (state_r)
      sha1_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.byte_val = in_byte;
        cmd.absorb = in_fire && in_has;
        cmd.count_en = in_fire && in_has;
        cmd.round_init = in_fire && in_has && sts.blk_full;
        cmd.save_len = in_fire;
      end
      sha1_pkg::ST_ROUND: begin
        cmd.round_step = 1'b1;
        cmd.round_fold = (sts.round == sha1_pkg::ROUNDS - 7'd1);
      end
      sha1_pkg::ST_PAD: begin
        cmd.byte_val = pad1_r ? 8'h80 : 8'h00;
        cmd.absorb = 1'b1;
        cmd.count_en = 1'b1;
        cmd.round_init = sts.blk_full;
        // save_len in IDLE caught count before the item's byte; refresh after it
        cmd.save_len = pad1_r;
      end
      sha1_pkg::ST_LEN: begin
        cmd.byte_val = sts.len[(3'd7 - lb_r)*8 +: 8];
        cmd.absorb = 1'b1;
        cmd.count_en = 1'b1;
        cmd.round_init = (lb_r == 3'd7);
      end
      sha1_pkg::ST_OUT: begin
        oreg_load = oreg_free;
        cmd.clear = oreg_free && (idx_r == 3'd4);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1_pkg::ST_IDLE;
      ret_r <= sha1_pkg::ST_IDLE;
      idx_r <= 3'd0;
      lb_r <= 3'd0;
      pad1_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      idx_r <= idx_nxt;
      lb_r <= lb_nxt;
      pad1_r <= pad1_nxt;
    end
  end
endmodule
`default_nettype wire

>>> verif/sha1_message_digest_test.sv
`timescale 1ns / 1ps
module sha1_message_digest_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  sha1_message_digest dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_out_t;

  typedef struct {
    logic [7:0]  data;
    logic        has;
    logic        eom;
    logic        typed;
    logic [31:0] w0;
  } stim_row_t;

  // predictor state
  logic [31:0] chain_h[5];
  logic [31:0] blk_w[16];
  logic [63:0] msg_bits;

  digest_out_t digest_q[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  recv_hold = 1'b0;
  bit  stim_done = 1'b0;

  function automatic logic [31:0] rol(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic hash_restart();
    chain_h[0] = sha1_pkg::H0; chain_h[1] = sha1_pkg::H1; chain_h[2] = sha1_pkg::H2;
    chain_h[3] = sha1_pkg::H3; chain_h[4] = sha1_pkg::H4;
    msg_bits = '0;
  endtask

  task automatic compress();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, wt, tmp;
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    w = blk_w;
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = rol(w[(t-3)&15] ^ w[(t-8)&15] ^ w[(t-14)&15] ^ w[t&15], 1);
        w[t&15] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d); k = sha1_pkg::K0;
      end else if (t < 40) begin
        f = b ^ c ^ d; k = sha1_pkg::K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2;
      end else begin
        f = b ^ c ^ d; k = sha1_pkg::K3;
      end
      tmp = rol(a, 5) + f + e + k + wt;
      e = d; d = c; c = rol(b, 30); b = a; a = tmp;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c;
    chain_h[3] += d; chain_h[4] += e;
  endtask

  task automatic absorb(input logic [7:0] v);
    logic [5:0] pos;
    pos = msg_bits[8:3];
    if (pos[1:0] == 2'd0)
      blk_w[pos[5:2]] = {v, 24'd0};
    else
      blk_w[pos[5:2]] |= {24'd0, v} << ((3 - pos[1:0]) * 8);
    msg_bits += 64'd8;
    if (pos == 6'd63)
      compress();
  endtask

  task automatic predict(input logic [7:0] v, input logic has, input logic eom);
    logic [63:0] len;
    digest_out_t r;
    if (has)
      absorb(v);
    if (eom) begin
      len = msg_bits;
      absorb(8'h80);
      while (msg_bits[8:3] != sha1_pkg::LEN_POS)
        absorb(8'h00);
      for (int i = 7; i >= 0; i--)
        absorb(len[i*8 +: 8]);
      for (int i = 0; i < 5; i++) begin
        r.word = chain_h[i]; r.index = i[2:0]; r.last = (i == 4);
        digest_q.push_back(r);
      end
      hash_restart();
    end
  endtask

  task automatic send(input logic [7:0] v, input logic has, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, has, v};
    in_tlast  <= eom;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    predict(v, has, eom);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (digest_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic send_msg(input int nbytes);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(9) == 0)
        send(8'($urandom), 1'b0, 1'b0);
      send(8'($urandom), 1'b1, (i == nbytes - 1) && ($urandom_range(1) != 0));
    end
    send(8'($urandom), 1'b0, 1'b1);
  endtask

  always @(posedge clk) begin
    out_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    digest_out_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got.word = out_tdata[31:0];
      got.index = out_tdata[34:32];
      got.last = out_tlast;
      if (digest_q.size() == 0) begin
        $error("digest word with none expected: %h", got.word);
        errors++;
      end else begin
        exp = digest_q.pop_front();
        if (got.word !== exp.word) begin
          $error("digest_word exp %h got %h", exp.word, got.word); errors++;
        end
        if (got.index !== exp.index) begin
          $error("word_index exp %0d got %0d", exp.index, got.index); errors++;
        end
        if (got.last !== exp.last) begin
          $error("last_word exp %0d got %0d", exp.last, got.last); errors++;
        end
      end
    end
  end

  stim_row_t dir_rows[] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'hda39a3ee},  // empty message
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},         // no byte, no end
    '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, 32'ha9993e36},  // "abc"
    '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'hff, 1'b0, 1'b0, 1'b0, 32'h0},         // ignored byte
    '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'haa, 1'b0, 1'b1, 1'b0, 32'h0},
    '{8'h55, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
    '{8'hff, 1'b1, 1'b1, 1'b0, 32'h0}
  };

  initial begin
    int hold_cycles;
    hash_restart();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send(dir_rows[i].data, dir_rows[i].has, dir_rows[i].eom);
      if (dir_rows[i].typed && digest_q.size() >= 5 &&
          digest_q[digest_q.size() - 5].word !== dir_rows[i].w0) begin
        $error("digest_word exp %h got %h", dir_rows[i].w0,
               digest_q[digest_q.size() - 5].word);
        errors++;
      end
    end
    drain();

    // block boundary lengths: 55, 56, 64
    send_msg(55); send_msg(56); send_msg(64);
    drain();

    // receiver held off while the sender keeps offering messages
    recv_hold = 1'b1;
    fork
      begin
        hold_cycles = 600;
        repeat (hold_cycles) @(posedge clk);
        recv_hold = 1'b0;
      end
      begin
        send_msg(2); send_msg(0); send_msg(3); send_msg(1);
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    join
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int m = 0; m < 3; m++)
        send_msg(int'($urandom_range(0, 8)));
      drain();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (200) @(posedge clk);
    if (errors == 0 && digest_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
